FILE: sv/sssp_pkg.sv
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared types, constants and helper functions for the shortest-path engine.
// ----------------------------------------------------------------------------
package sssp_pkg;

    localparam int MAX_VERTICES    = 64;
    localparam int MAX_EDGES       = 256;
    localparam int WEIGHT_BITS     = 16;
    localparam int DIST_BITS       = 24;

    localparam int VERTEX_BITS     = 6;
    localparam int COUNT_BITS      = 7;
    localparam int EDGE_ADDR_BITS  = $clog2(MAX_EDGES);
    localparam int EDGE_COUNT_BITS = $clog2(MAX_EDGES + 1);
    localparam int SUM_BITS        = DIST_BITS + 1;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 7;

    localparam logic signed [DIST_BITS-1:0] DIST_HI = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam logic signed [DIST_BITS-1:0] DIST_LO = {1'b1, {(DIST_BITS-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_VERTEX = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_COUNT  = 2'd1;

    typedef struct packed {
        logic [VERTEX_BITS-1:0]        edge_from;
        logic [VERTEX_BITS-1:0]        edge_to;
        logic signed [WEIGHT_BITS-1:0] edge_weight;
        logic                          edge_last;
    } edge_item_t;

    typedef struct packed {
        logic [VERTEX_BITS-1:0]      vertex_index;
        logic signed [DIST_BITS-1:0] distance;
        logic                        reachable;
        logic                        negative_cycle;
        logic                        edges_dropped;
        logic                        result_last;
    } result_item_t;

    typedef struct packed {
        logic [VERTEX_BITS-1:0]        from;
        logic [VERTEX_BITS-1:0]        to;
        logic signed [WEIGHT_BITS-1:0] weight;
    } stored_edge_t;

    typedef struct packed {
        logic                      en;
        logic [EDGE_ADDR_BITS-1:0] addr;
        stored_edge_t              data;
    } edge_wr_t;

    typedef struct packed {
        logic                        en;
        logic [VERTEX_BITS-1:0]      addr;
        logic signed [DIST_BITS-1:0] data;
    } dist_wr_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_PRIME,
        ST_DIST_RD,
        ST_RELAX,
        ST_OUT_RD,
        ST_OUT_PUT
    } engine_state_t;

    // Clamp the configured vertex count into 1..MAX_VERTICES.
    function automatic logic [COUNT_BITS-1:0] eff_vertices(input logic [COUNT_BITS-1:0] vc);
        logic [COUNT_BITS-1:0] r;
        if (vc == '0)
            r = COUNT_BITS'(1);
        else if (vc > COUNT_BITS'(MAX_VERTICES))
            r = COUNT_BITS'(MAX_VERTICES);
        else
            r = vc;
        return r;
    endfunction

    // Saturate an extended sum to the stored distance range.
    function automatic logic signed [DIST_BITS-1:0] sat_dist(
        input logic signed [SUM_BITS-1:0] s);
        logic signed [DIST_BITS-1:0] r;
        if (s[SUM_BITS-1] != s[SUM_BITS-2])
            r = s[SUM_BITS-1] ? DIST_LO : DIST_HI;
        else
            r = s[DIST_BITS-1:0];
        return r;
    endfunction

endpackage

FILE: sv/sssp_edge_mem.sv
// ----------------------------------------------------------------------------
// sssp_edge_mem
// Edge list storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sssp_edge_mem (
    input  logic                                clk,
    input  sssp_pkg::edge_wr_t                  wr,
    input  logic [sssp_pkg::EDGE_ADDR_BITS-1:0] raddr,
    output sssp_pkg::stored_edge_t              rdata
);

    sssp_pkg::stored_edge_t edge_ram [sssp_pkg::MAX_EDGES];
    sssp_pkg::stored_edge_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            edge_ram[wr.addr] <= wr.data;
        end
        rdata_reg <= edge_ram[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/sssp_dist_mem.sv
// ----------------------------------------------------------------------------
// sssp_dist_mem
// Per-vertex distance storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module sssp_dist_mem (
    input  logic                                    clk,
    input  sssp_pkg::dist_wr_t                      wr,
    input  logic [sssp_pkg::VERTEX_BITS-1:0]        raddr_a,
    input  logic [sssp_pkg::VERTEX_BITS-1:0]        raddr_b,
    output logic signed [sssp_pkg::DIST_BITS-1:0]   rdata_a,
    output logic signed [sssp_pkg::DIST_BITS-1:0]   rdata_b
);

    logic signed [sssp_pkg::DIST_BITS-1:0] dist_ram [sssp_pkg::MAX_VERTICES];
    logic signed [sssp_pkg::DIST_BITS-1:0] rdata_a_reg;
    logic signed [sssp_pkg::DIST_BITS-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            dist_ram[wr.addr] <= wr.data;
        end
        rdata_a_reg <= dist_ram[raddr_a];
        rdata_b_reg <= dist_ram[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: sv/sssp_engine.sv
// ----------------------------------------------------------------------------
// sssp_engine
// Edge loading, relaxation sequencer and result output register.
// ----------------------------------------------------------------------------
module sssp_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [sssp_pkg::VERTEX_BITS-1:0]      source_vertex,
    input  logic [sssp_pkg::COUNT_BITS-1:0]       vertex_limit,
    input  logic                                  edge_valid,
    output logic                                  edge_ready,
    input  sssp_pkg::edge_item_t                  edge_item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output sssp_pkg::result_item_t                result_item,
    output sssp_pkg::edge_wr_t                    edge_wr,
    output logic [sssp_pkg::EDGE_ADDR_BITS-1:0]   edge_raddr,
    input  sssp_pkg::stored_edge_t                edge_rdata,
    output sssp_pkg::dist_wr_t                    dist_wr,
    output logic [sssp_pkg::VERTEX_BITS-1:0]      dist_raddr_a,
    output logic [sssp_pkg::VERTEX_BITS-1:0]      dist_raddr_b,
    input  logic signed [sssp_pkg::DIST_BITS-1:0] dist_rdata_a,
    input  logic signed [sssp_pkg::DIST_BITS-1:0] dist_rdata_b
);

    sssp_pkg::engine_state_t state_reg, state_next;

    logic [sssp_pkg::EDGE_COUNT_BITS-1:0] edge_total_reg, edge_total_next;
    logic [sssp_pkg::EDGE_COUNT_BITS-1:0] edge_idx_reg, edge_idx_next;
    logic [sssp_pkg::COUNT_BITS-1:0]      pass_reg, pass_next;
    logic [sssp_pkg::VERTEX_BITS-1:0]     out_idx_reg, out_idx_next;
    logic [sssp_pkg::MAX_VERTICES-1:0]    reach_reg, reach_next;
    logic drop_seen_reg, drop_seen_next;
    logic check_phase_reg, check_phase_next;
    logic changed_reg, changed_next;
    logic neg_reg, neg_next;
    logic result_valid_reg, result_valid_next;

    sssp_pkg::stored_edge_t cur_edge_reg, cur_edge_next;
    sssp_pkg::result_item_t result_reg, result_next;

    logic edge_accept;
    logic load_ok;
    logic src_ok;
    logic cur_ok;
    logic reach_from;
    logic reach_to;
    logic better;
    logic changed_now;
    logic last_edge;
    logic pass_end;
    logic more_passes;
    logic out_free;
    logic out_last;
    logic signed [sssp_pkg::SUM_BITS-1:0] edge_sum;
    logic signed [sssp_pkg::SUM_BITS-1:0] dist_to_ext;

    assign edge_ready  = (state_reg == sssp_pkg::ST_LOAD);
    assign edge_accept = edge_valid && edge_ready;

    assign load_ok = (edge_total_reg < sssp_pkg::EDGE_COUNT_BITS'(sssp_pkg::MAX_EDGES))
                  && ({1'b0, edge_item.edge_from} < vertex_limit)
                  && ({1'b0, edge_item.edge_to} < vertex_limit);
    assign src_ok  = {1'b0, source_vertex} < vertex_limit;

    assign cur_ok     = ({1'b0, cur_edge_reg.from} < vertex_limit)
                     && ({1'b0, cur_edge_reg.to} < vertex_limit);
    assign reach_from = reach_reg[cur_edge_reg.from];
    assign reach_to   = reach_reg[cur_edge_reg.to];

    assign edge_sum    = {dist_rdata_a[sssp_pkg::DIST_BITS-1], dist_rdata_a}
                       + {{(sssp_pkg::SUM_BITS-sssp_pkg::WEIGHT_BITS)
                           {cur_edge_reg.weight[sssp_pkg::WEIGHT_BITS-1]}},
                          cur_edge_reg.weight};
    assign dist_to_ext = {dist_rdata_b[sssp_pkg::DIST_BITS-1], dist_rdata_b};

    // Same test serves relaxation (improve head) and the cycle check.
    assign better      = cur_ok && reach_from && (!reach_to || (edge_sum < dist_to_ext));
    assign changed_now = changed_reg || (better && !check_phase_reg);

    assign last_edge = sssp_pkg::EDGE_COUNT_BITS'(edge_idx_reg + 1'b1) == edge_total_reg;
    assign pass_end  = ((state_reg == sssp_pkg::ST_PRIME) && (edge_total_reg == '0))
                    || ((state_reg == sssp_pkg::ST_RELAX) && last_edge);
    assign more_passes = !check_phase_reg && changed_now
                      && (sssp_pkg::COUNT_BITS'(pass_reg + 1'b1) < vertex_limit);

    assign out_free = !result_valid_reg || result_ready;
    assign out_last = neg_reg
                   || (sssp_pkg::COUNT_BITS'({1'b0, out_idx_reg} + 1'b1) == vertex_limit);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sssp_pkg::ST_LOAD:
            begin
                if (edge_accept && edge_item.edge_last)
                    state_next = sssp_pkg::ST_INIT;
            end
            sssp_pkg::ST_INIT:
            begin
                state_next = sssp_pkg::ST_PRIME;
            end
            sssp_pkg::ST_PRIME:
            begin
                if (pass_end)
                    state_next = check_phase_reg ? sssp_pkg::ST_OUT_RD : sssp_pkg::ST_PRIME;
                else
                    state_next = sssp_pkg::ST_DIST_RD;
            end
            sssp_pkg::ST_DIST_RD:
            begin
                state_next = sssp_pkg::ST_RELAX;
            end
            sssp_pkg::ST_RELAX:
            begin
                if (pass_end)
                    state_next = check_phase_reg ? sssp_pkg::ST_OUT_RD : sssp_pkg::ST_PRIME;
                else
                    state_next = sssp_pkg::ST_DIST_RD;
            end
            sssp_pkg::ST_OUT_RD:
            begin
                state_next = sssp_pkg::ST_OUT_PUT;
            end
            sssp_pkg::ST_OUT_PUT:
            begin
                if (out_free)
                    state_next = out_last ? sssp_pkg::ST_LOAD : sssp_pkg::ST_OUT_RD;
            end
            default:
            begin
                state_next = sssp_pkg::ST_LOAD;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        edge_total_next   = edge_total_reg;
        edge_idx_next     = edge_idx_reg;
        pass_next         = pass_reg;
        out_idx_next      = out_idx_reg;
        reach_next        = reach_reg;
        drop_seen_next    = drop_seen_reg;
        check_phase_next  = check_phase_reg;
        changed_next      = changed_reg;
        neg_next          = neg_reg;
        cur_edge_next     = cur_edge_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        edge_wr.en        = 1'b0;
        edge_wr.addr      = edge_total_reg[sssp_pkg::EDGE_ADDR_BITS-1:0];
        edge_wr.data.from   = edge_item.edge_from;
        edge_wr.data.to     = edge_item.edge_to;
        edge_wr.data.weight = edge_item.edge_weight;
        edge_raddr        = sssp_pkg::EDGE_ADDR_BITS'(edge_idx_reg + 1'b1);

        dist_wr.en        = 1'b0;
        dist_wr.addr      = cur_edge_reg.to;
        dist_wr.data      = sssp_pkg::sat_dist(edge_sum);
        dist_raddr_a      = edge_rdata.from;
        dist_raddr_b      = edge_rdata.to;

        case (state_reg)
            sssp_pkg::ST_LOAD:
            begin
                if (edge_accept)
                begin
                    if (load_ok)
                    begin
                        edge_wr.en      = 1'b1;
                        edge_total_next = sssp_pkg::EDGE_COUNT_BITS'(edge_total_reg + 1'b1);
                    end
                    else
                    begin
                        drop_seen_next = 1'b1;
                    end
                end
            end
            sssp_pkg::ST_INIT:
            begin
                // Everything unreachable, source at distance zero
                reach_next = '0;
                if (src_ok)
                begin
                    reach_next[source_vertex] = 1'b1;
                    dist_wr.en   = 1'b1;
                    dist_wr.addr = source_vertex;
                    dist_wr.data = '0;
                end
                pass_next        = sssp_pkg::COUNT_BITS'(1);
                check_phase_next = !(vertex_limit > sssp_pkg::COUNT_BITS'(1));
                edge_idx_next    = '0;
                changed_next     = 1'b0;
                neg_next         = 1'b0;
            end
            sssp_pkg::ST_PRIME:
            begin
                edge_raddr = edge_idx_reg[sssp_pkg::EDGE_ADDR_BITS-1:0];
            end
            sssp_pkg::ST_DIST_RD:
            begin
                cur_edge_next = edge_rdata;
            end
            sssp_pkg::ST_RELAX:
            begin
                if (check_phase_reg)
                begin
                    if (!cur_ok)
                        drop_seen_next = 1'b1;
                    if (better)
                        neg_next = 1'b1;
                end
                else if (better)
                begin
                    dist_wr.en                   = 1'b1;
                    reach_next[cur_edge_reg.to]  = 1'b1;
                    changed_next                 = 1'b1;
                end
                edge_idx_next = sssp_pkg::EDGE_COUNT_BITS'(edge_idx_reg + 1'b1);
            end
            sssp_pkg::ST_OUT_RD:
            begin
                dist_raddr_a = out_idx_reg;
            end
            sssp_pkg::ST_OUT_PUT:
            begin
                dist_raddr_a = out_idx_reg;
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        result_next.vertex_index   = '0;
                        result_next.distance       = '0;
                        result_next.reachable      = 1'b0;
                        result_next.negative_cycle = 1'b1;
                    end
                    else
                    begin
                        result_next.vertex_index   = out_idx_reg;
                        result_next.distance       = reach_reg[out_idx_reg] ? dist_rdata_a : '0;
                        result_next.reachable      = reach_reg[out_idx_reg];
                        result_next.negative_cycle = 1'b0;
                    end
                    result_next.edges_dropped = drop_seen_reg;
                    result_next.result_last   = out_last;
                    if (out_last)
                    begin
                        edge_total_next = '0;
                        drop_seen_next  = 1'b0;
                    end
                    else
                    begin
                        out_idx_next = sssp_pkg::VERTEX_BITS'(out_idx_reg + 1'b1);
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Wrap up a pass: next relax pass, move on to the check, or report
        if (pass_end)
        begin
            edge_idx_next = '0;
            changed_next  = 1'b0;
            out_idx_next  = '0;
            if (!check_phase_reg)
            begin
                if (more_passes)
                    pass_next = sssp_pkg::COUNT_BITS'(pass_reg + 1'b1);
                else
                    check_phase_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sssp_pkg::ST_LOAD;
            edge_total_reg   <= '0;
            edge_idx_reg     <= '0;
            pass_reg         <= '0;
            out_idx_reg      <= '0;
            reach_reg        <= '0;
            drop_seen_reg    <= 1'b0;
            check_phase_reg  <= 1'b0;
            changed_reg      <= 1'b0;
            neg_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            edge_total_reg   <= edge_total_next;
            edge_idx_reg     <= edge_idx_next;
            pass_reg         <= pass_next;
            out_idx_reg      <= out_idx_next;
            reach_reg        <= reach_next;
            drop_seen_reg    <= drop_seen_next;
            check_phase_reg  <= check_phase_next;
            changed_reg      <= changed_next;
            neg_reg          <= neg_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_edge_reg <= cur_edge_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

endmodule

FILE: sv/single_source_shortest_paths_top.sv
// Sequence: edges load at one transfer per cycle while the engine is in its load state.
//   After the last edge, the run makes P relaxation passes over the E stored edges (P at
//   most the effective vertex count - 1), then one check pass, then hands out the results.
//   Each edge goes through a distance memory read state and a relax state that writes back.
// Reset: source_vertex 0, vertex_count 64, edge list empty; memories are not cleared,
//   reach flags mask any distance that the current run has not written.
// ----------------------------------------------------------------------------
// single_source_shortest_paths_top
// Bellman-Ford shortest paths over a loaded edge list, with negative cycle check.
// ----------------------------------------------------------------------------
module single_source_shortest_paths_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Edge input channel
    input  logic                                   edge_valid,
    output logic                                   edge_ready,
    input  sssp_pkg::edge_item_t                   edge_item,
    // Result channel
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output sssp_pkg::result_item_t                 result_item,
    // Configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sssp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [sssp_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    logic [sssp_pkg::VERTEX_BITS-1:0] source_vertex_reg, source_vertex_next;
    logic [sssp_pkg::COUNT_BITS-1:0]  vertex_count_reg, vertex_count_next;
    logic [sssp_pkg::COUNT_BITS-1:0]  vertex_limit;

    sssp_pkg::edge_wr_t                    edge_wr;
    logic [sssp_pkg::EDGE_ADDR_BITS-1:0]   edge_raddr;
    sssp_pkg::stored_edge_t                edge_rdata;
    sssp_pkg::dist_wr_t                    dist_wr;
    logic [sssp_pkg::VERTEX_BITS-1:0]      dist_raddr_a;
    logic [sssp_pkg::VERTEX_BITS-1:0]      dist_raddr_b;
    logic signed [sssp_pkg::DIST_BITS-1:0] dist_rdata_a;
    logic signed [sssp_pkg::DIST_BITS-1:0] dist_rdata_b;

    // The user must issue configuration writes only while idle; the block does not enforce it.
    assign cfg_ready = 1'b1;

    // Decode a configuration transfer; unknown indexes are dropped.
    always_comb
    begin
        source_vertex_next = source_vertex_reg;
        vertex_count_next  = vertex_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sssp_pkg::CFG_SOURCE_VERTEX:
                begin
                    source_vertex_next = cfg_data[sssp_pkg::VERTEX_BITS-1:0];
                end
                sssp_pkg::CFG_VERTEX_COUNT:
                begin
                    vertex_count_next = cfg_data[sssp_pkg::COUNT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_vertex_reg <= '0;
            vertex_count_reg  <= sssp_pkg::COUNT_BITS'(sssp_pkg::MAX_VERTICES);
        end
        else
        begin
            source_vertex_reg <= source_vertex_next;
            vertex_count_reg  <= vertex_count_next;
        end
    end

    // Zero acts as one vertex, anything above the capacity as the full capacity.
    assign vertex_limit = sssp_pkg::eff_vertices(vertex_count_reg);

    // Sequencer: loads edges, runs the passes, hands out results
    sssp_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .source_vertex (source_vertex_reg),
        .vertex_limit  (vertex_limit),
        .edge_valid    (edge_valid),
        .edge_ready    (edge_ready),
        .edge_item     (edge_item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_item   (result_item),
        .edge_wr       (edge_wr),
        .edge_raddr    (edge_raddr),
        .edge_rdata    (edge_rdata),
        .dist_wr       (dist_wr),
        .dist_raddr_a  (dist_raddr_a),
        .dist_raddr_b  (dist_raddr_b),
        .dist_rdata_a  (dist_rdata_a),
        .dist_rdata_b  (dist_rdata_b)
    );

    // Edge list, indexed in arrival order
    sssp_edge_mem u_edge_mem (
        .clk   (clk),
        .wr    (edge_wr),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // Distances: port A reads the tail (or the vertex being reported), port B the head
    sssp_dist_mem u_dist_mem (
        .clk     (clk),
        .wr      (dist_wr),
        .raddr_a (dist_raddr_a),
        .raddr_b (dist_raddr_b),
        .rdata_a (dist_rdata_a),
        .rdata_b (dist_rdata_b)
    );

endmodule

FILE: dv/tb_single_source_shortest_paths_top.sv
// ----------------------------------------------------------------------------
// tb_single_source_shortest_paths_top
// Self-checking bench for the Bellman-Ford engine: loads edge lists through the
// edge channel, rewrites source and vertex count between runs and the count mid-list, and compares every
// distance transfer against an in-bench shortest-path solver or, for typed rows, a hand-set route.
// ----------------------------------------------------------------------------
module tb_single_source_shortest_paths_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sssp_pkg::*;

    // Register indexes that decode to nothing; writes there must be ignored.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_HI = 2'd3;

    localparam int RANDOM_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 8;       // return to load after the last result
    localparam int STALL_LIMIT   = 200000;  // watchdog bound, well above the longest run
    localparam int PRINT_CAP     = 50;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum {ROW_CFG, ROW_EDGE} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [CFG_INDEX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0]   data;
        edge_item_t                 item;
        bit                         typed;
        result_item_t               want;
    } row_t;

    typedef struct {
        int     from;
        int     to;
        longint weight;
    } arc_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       edge_valid = 1'b0;
    logic                       edge_ready;
    edge_item_t                 edge_item = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    result_item_t               result_item;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

    single_source_shortest_paths_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_ready   (edge_ready),
        .edge_item    (edge_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shortest-path solver: mirrors the engine's edge list, flags and registers.
    // ------------------------------------------------------------------------
    arc_t                   arc_list[MAX_EDGES];
    int                     arc_cnt = 0;
    bit                     drop_pending = 1'b0;
    logic [VERTEX_BITS-1:0] src_reg = '0;
    logic [COUNT_BITS-1:0]  vcount_reg = 7'd64;
    longint                 dist_now[MAX_VERTICES];
    bit                     reach_now[MAX_VERTICES];
    result_item_t           fresh_q[$];        // routes produced by the latest edge
    result_item_t           pending_routes[$]; // routes still owed by the engine
    row_t                   plan[$];

    int send_pct = 0;
    int recv_pct = 0;
    int mismatch_cnt = 0;
    int quiet_cycles = 0;
    result_item_t head_route;

    // Zero acts as one vertex, anything past the array acts as the full array.
    function automatic int active_vertices();
        if (vcount_reg == 0)
            return 1;
        if (vcount_reg > MAX_VERTICES)
            return MAX_VERTICES;
        return int'(vcount_reg);
    endfunction

    function automatic longint clamp_dist(longint s);
        if (s > longint'(DIST_HI))
            return longint'(DIST_HI);
        if (s < longint'(DIST_LO))
            return longint'(DIST_LO);
        return s;
    endfunction

    function automatic bit arc_fits(arc_t a, int nv);
        return a.from < nv && a.to < nv;
    endfunction

    function automatic void write_shadow(logic [CFG_INDEX_BITS-1:0] idx,
                                         logic [CFG_DATA_BITS-1:0] data);
        if (idx == CFG_SOURCE_VERTEX)
            src_reg = data[VERTEX_BITS-1:0];
        else if (idx == CFG_VERTEX_COUNT)
            vcount_reg = data;
    endfunction

    // Store or drop one edge; on the last edge solve and fill fresh_q.
    function automatic void take_edge(edge_item_t it);
        int           nv;
        longint       s;
        bit           changed;
        bit           neg;
        bit           dropped;
        arc_t         a;
        result_item_t r;

        fresh_q.delete();
        nv = active_vertices();
        a.from = int'(it.edge_from);
        a.to = int'(it.edge_to);
        a.weight = longint'(it.edge_weight);
        if (arc_cnt >= MAX_EDGES || !arc_fits(a, nv))
            drop_pending = 1'b1;
        else
        begin
            arc_list[arc_cnt] = a;
            arc_cnt++;
        end
        if (!it.edge_last)
            return;

        // Stored edges that no longer fit the vertex count are skipped and flagged.
        for (int i = 0; i < arc_cnt; i++)
            if (!arc_fits(arc_list[i], nv))
                drop_pending = 1'b1;

        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            dist_now[v] = 0;
            reach_now[v] = 1'b0;
        end
        if (src_reg < nv)
            reach_now[src_reg] = 1'b1;

        for (int p = 1; p < nv; p++)
        begin
            changed = 1'b0;
            for (int j = 0; j < arc_cnt; j++)
            begin
                a = arc_list[j];
                if (arc_fits(a, nv) && reach_now[a.from])
                begin
                    s = dist_now[a.from] + a.weight;
                    if (!reach_now[a.to] || s < dist_now[a.to])
                    begin
                        dist_now[a.to] = clamp_dist(s);
                        reach_now[a.to] = 1'b1;
                        changed = 1'b1;
                    end
                end
            end
            if (!changed)
                break;
        end

        // One more pass: any further improvement means a reachable negative cycle.
        neg = 1'b0;
        for (int j = 0; j < arc_cnt && !neg; j++)
        begin
            a = arc_list[j];
            if (arc_fits(a, nv) && reach_now[a.from])
                if (!reach_now[a.to] || dist_now[a.from] + a.weight < dist_now[a.to])
                    neg = 1'b1;
        end

        dropped = drop_pending;
        arc_cnt = 0;
        drop_pending = 1'b0;

        r = '0;
        r.edges_dropped = dropped;
        if (neg)
        begin
            r.negative_cycle = 1'b1;
            r.result_last = 1'b1;
            fresh_q.push_back(r);
            return;
        end
        for (int v = 0; v < nv; v++)
        begin
            r.vertex_index = VERTEX_BITS'(v);
            r.reachable = reach_now[v];
            r.distance = reach_now[v] ? DIST_BITS'(dist_now[v]) : '0;
            r.result_last = (v == nv - 1);
            fresh_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------
    function automatic row_t cfg_row(logic [CFG_INDEX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] data);
        row_t r;
        r = '{kind: ROW_CFG, idx: '0, data: '0, item: '0, typed: 1'b0, want: '0};
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic row_t edge_row(int f, int t, int w, bit last);
        row_t r;
        r = '{kind: ROW_EDGE, idx: '0, data: '0, item: '0, typed: 1'b0, want: '0};
        r.kind = ROW_EDGE;
        r.item.edge_from = VERTEX_BITS'(f);
        r.item.edge_to = VERTEX_BITS'(t);
        r.item.edge_weight = WEIGHT_BITS'(w);
        r.item.edge_last = last;
        return r;
    endfunction

    // Rows whose single route (vertex 0, last) is known by inspection.
    function automatic row_t typed_row(int f, int t, int w, int d, bit reach,
                                       bit neg, bit drop);
        row_t r;
        r = edge_row(f, t, w, 1'b1);
        r.typed = 1'b1;
        r.want.vertex_index = '0;
        r.want.distance = DIST_BITS'(d);
        r.want.reachable = reach;
        r.want.negative_cycle = neg;
        r.want.edges_dropped = drop;
        r.want.result_last = 1'b1;
        return r;
    endfunction

    function automatic void set_idle(idle_mode_t m);
        send_pct = (m == IDLE_SEND) ? 61 : (m == IDLE_BOTH) ? 37 : 0;
        recv_pct = (m == IDLE_RECV) ? 61 : (m == IDLE_BOTH) ? 37 : 0;
    endfunction

    task automatic note_mismatch(string what, logic [39:0] got, logic [39:0] want);
        if (mismatch_cnt < PRINT_CAP)
            $display("%0t ns: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Driving tasks; all input changes land on the falling edge.
    // ------------------------------------------------------------------------

    // Drop edge valid and hold until every owed route has arrived, then let
    // the engine fall back to loading.
    task automatic drain_routes();
        @(negedge clk);
        edge_valid <= 1'b0;
        while (pending_routes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                             logic [CFG_DATA_BITS-1:0] data);
        drain_routes();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        write_shadow(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one edge, with random idle cycles ahead of it; valid stays high
    // until the next falling edge so back-to-back transfers need no gap.
    task automatic send_edge(edge_item_t it, bit typed, result_item_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_pct)
        begin
            edge_valid <= 1'b0;
            @(negedge clk);
        end
        edge_valid <= 1'b1;
        edge_item <= it;
        do @(posedge clk); while (!(edge_valid && edge_ready));
        take_edge(it);
        if (typed)
            pending_routes.push_back(want);
        else
            foreach (fresh_q[k])
                pending_routes.push_back(fresh_q[k]);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, field-by-field compare, watchdog.
    // ------------------------------------------------------------------------
    always @(negedge clk)
        result_ready <= ($urandom_range(0, 99) >= recv_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (edge_valid && edge_ready) || (result_valid && result_ready)
                || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d routes owed",
                     quiet_cycles, pending_routes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else if (rst_n && result_valid && result_ready)
        begin
            if (pending_routes.size() == 0)
                note_mismatch("unexpected route", 40'(result_item), '0);
            else
            begin
                head_route = pending_routes.pop_front();
                if (result_item.vertex_index !== head_route.vertex_index)
                    note_mismatch("vertex_index", 40'(result_item.vertex_index),
                                  40'(head_route.vertex_index));
                if (result_item.distance !== head_route.distance)
                    note_mismatch("distance", 40'(result_item.distance),
                                  40'(head_route.distance));
                if (result_item.reachable !== head_route.reachable)
                    note_mismatch("reachable", 40'(result_item.reachable),
                                  40'(head_route.reachable));
                if (result_item.negative_cycle !== head_route.negative_cycle)
                    note_mismatch("negative_cycle", 40'(result_item.negative_cycle),
                                  40'(head_route.negative_cycle));
                if (result_item.edges_dropped !== head_route.edges_dropped)
                    note_mismatch("edges_dropped", 40'(result_item.edges_dropped),
                                  40'(head_route.edges_dropped));
                if (result_item.result_last !== head_route.result_last)
                    note_mismatch("result_last", 40'(result_item.result_last),
                                  40'(head_route.result_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        edge_item_t             item;
        result_item_t           none;
        int                     nv;
        int                     n_arcs;
        int                     style;
        int                     from;
        int                     to;
        int                     w;
        int                     tail;
        int                     run_no;
        int                     rand_items;
        logic [CFG_DATA_BITS-1:0] vc_pick;

        none = '0;

        // Reset defaults: source 0 over all 64 vertices, only vertex 0 reachable.
        plan.push_back(edge_row(0, 0, 0, 1'b1));
        // Single vertex: a heavy self loop changes nothing.
        plan.push_back(cfg_row(CFG_VERTEX_COUNT, 7'd1));
        plan.push_back(typed_row(0, 0, 32767, 0, 1'b1, 1'b0, 1'b0));
        // Last edge itself out of range: dropped, run still computes.
        plan.push_back(typed_row(63, 0, -32768, 0, 1'b1, 1'b0, 1'b1));
        // Count zero acts as one; source beyond the count reaches nothing;
        // writes to an undecoded index are ignored.
        plan.push_back(cfg_row(CFG_VERTEX_COUNT, 7'd0));
        plan.push_back(cfg_row(CFG_SOURCE_VERTEX, 7'd63));
        plan.push_back(cfg_row(CFG_UNUSED_HI, 7'h7F));
        plan.push_back(typed_row(0, 0, 5, 0, 1'b0, 1'b0, 1'b0));
        // Source data bit 6 is ignored; count above 64 acts as 64.
        plan.push_back(cfg_row(CFG_SOURCE_VERTEX, 7'h40));
        plan.push_back(cfg_row(CFG_VERTEX_COUNT, 7'd127));
        // Loop 0 -> 1 -> 0 of total weight -1: negative cycle.
        plan.push_back(edge_row(0, 1, -32768, 1'b0));
        plan.push_back(typed_row(1, 0, 32767, 0, 1'b0, 1'b1, 1'b0));
        // Largest positive weight on a two-vertex graph.
        plan.push_back(cfg_row(CFG_VERTEX_COUNT, 7'd2));
        plan.push_back(edge_row(0, 1, 32767, 1'b1));
        // Twelve most-negative edges per pass over 63 passes drive the stored
        // distances into saturation before the cycle check.
        plan.push_back(cfg_row(CFG_VERTEX_COUNT, 7'd64));
        for (int k = 0; k < 11; k++)
            plan.push_back(edge_row(k % 2, (k + 1) % 2, -32768, 1'b0));
        plan.push_back(typed_row(1, 0, -32768, 0, 1'b0, 1'b1, 1'b0));
        // Edge stored under four vertices, skipped once the count drops to three.
        plan.push_back(cfg_row(CFG_VERTEX_COUNT, 7'd4));
        plan.push_back(edge_row(3, 2, 7, 1'b0));
        plan.push_back(cfg_row(CFG_VERTEX_COUNT, 7'd3));
        plan.push_back(edge_row(0, 1, 2, 1'b1));

        set_idle(IDLE_NONE);
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_CFG)
                write_reg(plan[r].idx, plan[r].data);
            else
                send_edge(plan[r].item, plan[r].typed, plan[r].want);
        end

        // Random runs: mostly well-formed lists with chained edges out of the
        // source, some out-of-range noise, occasional mid-list count changes.
        // Step through the idle phases one run at a time.
        run_no = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            set_idle(idle_mode_t'(run_no % 4));
            // Hold off the sender until every owed route is back.
            if (run_no == 3 || $urandom_range(0, 9) == 0)
                drain_routes();

            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 19))
                    0:       vc_pick = 7'd0;
                    1:       vc_pick = CFG_DATA_BITS'($urandom_range(65, 127));
                    2, 3, 4: vc_pick = 7'd64;
                    5, 6, 7, 8, 9:
                             vc_pick = CFG_DATA_BITS'($urandom_range(17, 63));
                    default: vc_pick = CFG_DATA_BITS'($urandom_range(1, 16));
                endcase
                write_reg(CFG_VERTEX_COUNT, vc_pick);
                nv = active_vertices();
                if ($urandom_range(0, 1) == 1)
                    write_reg(CFG_SOURCE_VERTEX,
                              {1'($urandom_range(0, 1)),
                               VERTEX_BITS'(($urandom_range(0, 7) != 0) ?
                                            $urandom_range(0, nv - 1) :
                                            $urandom_range(0, 63))});
                if ($urandom_range(0, 15) == 0)
                    write_reg(CFG_UNUSED_LO, CFG_DATA_BITS'($urandom_range(0, 127)));
            end

            nv = active_vertices();
            n_arcs = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30)
                                                 : $urandom_range(1, 12);
            style = $urandom_range(0, 19);
            tail = int'(src_reg);
            for (int k = 0; k < n_arcs; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    from = $urandom_range(0, 63);
                    to = $urandom_range(0, 63);
                end
                else
                begin
                    from = ($urandom_range(0, 1) == 1) ? tail : $urandom_range(0, nv - 1);
                    to = $urandom_range(0, nv - 1);
                end
                if (style < 8)
                    w = $urandom_range(0, 100);
                else if (style < 13)
                    w = int'($urandom_range(0, 120)) - 20;
                else if (style < 16)
                    w = int'($urandom_range(0, 65535)) - 32768;
                else
                    w = $urandom_range(0, 32767);

                item.edge_from = VERTEX_BITS'(from);
                item.edge_to = VERTEX_BITS'(to);
                item.edge_weight = WEIGHT_BITS'(w);
                item.edge_last = (k == n_arcs - 1);

                // Shrink or grow the graph under a half-loaded list.
                if (k == 1 && $urandom_range(0, 19) == 0)
                begin
                    write_reg(CFG_VERTEX_COUNT, CFG_DATA_BITS'($urandom_range(1, 64)));
                    nv = active_vertices();
                end
                send_edge(item, 1'b0, none);
                tail = to;
                rand_items++;
            end
            run_no++;
        end

        // Overfill the edge store: the edges past MAX_EDGES are dropped,
        // the last of them still starts the run.
        set_idle(IDLE_NONE);
        write_reg(CFG_VERTEX_COUNT, 7'd64);
        write_reg(CFG_SOURCE_VERTEX, 7'd0);
        for (int k = 0; k < MAX_EDGES + 2; k++)
        begin
            item.edge_from = VERTEX_BITS'((k == 0) ? 0 : $urandom_range(0, 63));
            item.edge_to = VERTEX_BITS'($urandom_range(0, 63));
            item.edge_weight = WEIGHT_BITS'($urandom_range(0, 1000));
            item.edge_last = (k == MAX_EDGES + 1);
            send_edge(item, 1'b0, none);
        end

        // Wait out the last routes plus a short tail for strays.
        drain_routes();
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
